// ===== rtl/sfd_pkg.sv =====
// sfd_pkg: shared types and constants of the serial packet framer/deframer
// depends on nothing; imported by the core, the checker and the testbench

package sfd_pkg;

   // request actions
   localparam logic [2:0] ACT_RX_BYTE  = 3'd0;
   localparam logic [2:0] ACT_LINE_IDLE = 3'd1;
   localparam logic [2:0] ACT_LOAD     = 3'd2;
   localparam logic [2:0] ACT_TX_START = 3'd3;
   localparam logic [2:0] ACT_TX_READY = 3'd4;

   // response kinds
   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_LINE     = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd2;
   localparam logic [1:0] KIND_COMPLETE = 2'd3;

   // line markers
   localparam logic [7:0] MARK_PING  = 8'hA8;
   localparam logic [7:0] MARK_START = 8'hAE;
   localparam logic [7:0] MARK_END   = 8'hAB;

   typedef enum logic [3:0] {
      RX_HUNT  = 4'b0001,
      RX_LEN   = 4'b0010,
      RX_DATA  = 4'b0100,
      RX_CHECK = 4'b1000
   } rx_phase_type;

   typedef enum logic [2:0] {
      TX_LEN  = 3'b001,
      TX_DATA = 3'b010,
      TX_END  = 3'b100
   } tx_phase_type;

   // one response held in the output stage
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] position;
      logic [7:0] packet_length;
      logic       tx_busy;
      logic       use_ram;   // out_byte comes from the buffer read port
   } rsp_type;

endpackage

// ===== rtl/sfd_ram.sv =====
// sfd_ram: generic single-write, single-read ram with registered read data
// no dependencies

module sfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/serial_packet_framer_deframer_core.sv =====
// serial_packet_framer_deframer_core: receive deframer and transmit framer
// depends on sfd_pkg and sfd_ram
//
// usage:
//   req_ channel carries one event per transfer: a received line byte, a
//   line-idle event, a load into the transmit buffer, a transmit start or a
//   transmitter-ready event. every request gives exactly one response on the
//   rsp_ channel (kind 0 when there is nothing to report).
//   the response is registered: the response of a request taken at edge t is
//   valid after that edge. a new request is taken every cycle as long as
//   the response stage is empty or its response is taken in the same cycle,
//   so sustained throughput is one request per cycle.
//   the transmit buffer is a ram with registered read data; a payload byte
//   is read when the ready event is taken and lands beside the response.
//   a load taken in one cycle is visible to a read in the next.
//   when the receiver stalls rsp_ready low, the response holds and req_ready
//   drops until it is taken.
//   reset (synchronous) puts the receiver in hunt and the transmitter idle;
//   buffer contents are kept and are undefined until loaded.

module serial_packet_framer_deframer_core #(
   parameter int TX_BUFFER_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_load_index,
   input  logic [7:0] req_tx_length,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_position,
   output logic [7:0] rsp_packet_length,
   output logic       rsp_tx_busy
);

   import sfd_pkg::*;

   localparam int AW = $clog2(TX_BUFFER_DEPTH);

   typedef logic [AW-1:0] addr_table_type [256];

   // byte index to buffer address, index taken modulo the depth
   function automatic addr_table_type build_addr_table();
      addr_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = AW'(i % TX_BUFFER_DEPTH);
      end
      return t;
   endfunction

   localparam addr_table_type ADDR_TABLE = build_addr_table();

   rx_phase_type rx_phase_ff, rx_phase_in;
   logic [7:0]   rx_remaining_ff, rx_remaining_in;
   logic [7:0]   rx_count_ff, rx_count_in;
   logic [7:0]   rx_position_ff, rx_position_in;
   tx_phase_type tx_phase_ff, tx_phase_in;
   logic [7:0]   tx_count_ff, tx_count_in;
   logic [7:0]   tx_position_ff, tx_position_in;
   logic         tx_active_ff, tx_active_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         accept;
   logic         ram_wr_en;
   logic         ram_rd_en;
   logic [7:0]   ram_rd_data;
   logic [7:0]   rx_remaining_dec;
   logic [7:0]   tx_position_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign rx_remaining_dec = rx_remaining_ff - 8'd1;
   assign tx_position_inc  = tx_position_ff + 8'd1;

   always_comb begin
      rx_phase_in     = rx_phase_ff;
      rx_remaining_in = rx_remaining_ff;
      rx_count_in     = rx_count_ff;
      rx_position_in  = rx_position_ff;
      tx_phase_in     = tx_phase_ff;
      tx_count_in     = tx_count_ff;
      tx_position_in  = tx_position_ff;
      tx_active_in    = tx_active_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      rsp_in          = '0;

      if (accept) begin
         unique case (req_action)
            ACT_RX_BYTE: begin
               unique case (rx_phase_ff)
                  RX_HUNT: begin
                     if (req_byte_value == MARK_PING) begin
                        rsp_in.kind     = KIND_LINE;
                        rsp_in.out_byte = MARK_PING;
                     end else if (req_byte_value == MARK_START) begin
                        rx_phase_in = RX_LEN;
                     end
                  end
                  RX_LEN: begin
                     rx_count_in     = req_byte_value;
                     rx_remaining_in = req_byte_value;
                     rx_position_in  = 8'd0;
                     rx_phase_in     = (req_byte_value == 8'd0) ? RX_CHECK : RX_DATA;
                  end
                  RX_DATA: begin
                     rsp_in.kind     = KIND_PAYLOAD;
                     rsp_in.out_byte = req_byte_value;
                     rsp_in.position = rx_position_ff;
                     rx_position_in  = rx_position_ff + 8'd1;
                     rx_remaining_in = rx_remaining_dec;
                     if (rx_remaining_dec == 8'd0) begin
                        rx_phase_in = RX_CHECK;
                     end
                  end
                  RX_CHECK: begin
                     rsp_in.kind          = KIND_COMPLETE;
                     rsp_in.packet_length = rx_count_ff;
                     rx_phase_in          = RX_HUNT;
                  end
                  default: begin
                     rx_phase_in = RX_HUNT;
                  end
               endcase
            end
            ACT_LINE_IDLE: begin
               rx_phase_in = RX_HUNT;
            end
            ACT_LOAD: begin
               ram_wr_en = 1'b1;
            end
            ACT_TX_START: begin
               tx_phase_in     = TX_LEN;
               tx_count_in     = req_tx_length;
               tx_position_in  = 8'd0;
               tx_active_in    = 1'b1;
               rsp_in.kind     = KIND_LINE;
               rsp_in.out_byte = MARK_START;
            end
            ACT_TX_READY: begin
               if (tx_active_ff) begin
                  rsp_in.kind = KIND_LINE;
                  unique case (tx_phase_ff)
                     TX_LEN: begin
                        rsp_in.out_byte = tx_count_ff;
                        tx_phase_in     = (tx_count_ff != 8'd0) ? TX_DATA : TX_END;
                     end
                     TX_DATA: begin
                        ram_rd_en      = 1'b1;
                        rsp_in.use_ram = 1'b1;
                        tx_position_in = tx_position_inc;
                        if (tx_position_inc == tx_count_ff) begin
                           tx_phase_in = TX_END;
                        end
                     end
                     TX_END: begin
                        rsp_in.out_byte = MARK_END;
                        tx_active_in    = 1'b0;
                     end
                     default: begin
                        rsp_in.out_byte = MARK_END;
                        tx_active_in    = 1'b0;
                     end
                  endcase
               end
            end
            default: begin
               // unknown actions change nothing
            end
         endcase
         rsp_in.tx_busy = tx_active_in;
      end
   end

   // a taken request always fills the response stage
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff     <= RX_HUNT;
         rx_remaining_ff <= 8'd0;
         rx_count_ff     <= 8'd0;
         rx_position_ff  <= 8'd0;
         tx_phase_ff     <= TX_LEN;
         tx_count_ff     <= 8'd0;
         tx_position_ff  <= 8'd0;
         tx_active_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rx_phase_ff     <= rx_phase_in;
         rx_remaining_ff <= rx_remaining_in;
         rx_count_ff     <= rx_count_in;
         rx_position_ff  <= rx_position_in;
         tx_phase_ff     <= tx_phase_in;
         tx_count_ff     <= tx_count_in;
         tx_position_ff  <= tx_position_in;
         tx_active_ff    <= tx_active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   sfd_ram #(
      .WIDTH (8),
      .DEPTH (TX_BUFFER_DEPTH)
   ) u_tx_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_TABLE[req_load_index]),
      .wr_data (req_byte_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ADDR_TABLE[tx_position_ff]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_out_byte      = rsp_ff.use_ram ? ram_rd_data : rsp_ff.out_byte;
   assign rsp_position      = rsp_ff.position;
   assign rsp_packet_length = rsp_ff.packet_length;
   assign rsp_tx_busy       = rsp_ff.tx_busy;

endmodule

// ===== verif/sfd_response_checker.sv =====
// sfd_response_checker: watches both channels of the framer/deframer core,
// predicts every response from the accepted requests and compares them
// depends on sfd_pkg for actions, kinds, markers and phase enums

module sfd_response_checker
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_load_index,
   input  logic [7:0] req_tx_length,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_out_byte,
   input  logic [7:0] rsp_position,
   input  logic [7:0] rsp_packet_length,
   input  logic       rsp_tx_busy,
   output int         fail_count,
   output int         owed
);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] position;
      logic [7:0] packet_length;
      logic       tx_busy;
   } framer_rsp_type;

   framer_rsp_type owed_q [$];

   // shadow copy of the deframer and framer state
   rx_phase_type rx_st;
   logic [7:0]   rx_left;
   logic [7:0]   rx_len;
   logic [7:0]   rx_pos;
   tx_phase_type tx_st;
   logic [7:0]   tx_len;
   logic [7:0]   tx_pos;
   logic         tx_on;
   logic [7:0]   tx_buf [0:255];

   task automatic report(input string msg);
      begin
         $display("mismatch at %0t: %s", $time, msg);
         fail_count = fail_count + 1;
      end
   endtask

   task automatic step_framer(input logic [2:0] act, input logic [7:0] b,
                              input logic [7:0] idx, input logic [7:0] len,
                              output framer_rsp_type r);
      begin
         r = '0;
         case (act)
            ACT_RX_BYTE: begin
               case (rx_st)
                  RX_HUNT: begin
                     if (b == MARK_PING) begin
                        r.kind = KIND_LINE;
                        r.out_byte = MARK_PING;
                     end else if (b == MARK_START) begin
                        rx_st = RX_LEN;
                     end
                  end
                  RX_LEN: begin
                     rx_len = b;
                     rx_left = b;
                     rx_pos = 8'd0;
                     if (b == 8'd0) rx_st = RX_CHECK;
                     else rx_st = RX_DATA;
                  end
                  RX_DATA: begin
                     r.kind = KIND_PAYLOAD;
                     r.out_byte = b;
                     r.position = rx_pos;
                     rx_pos = rx_pos + 8'd1;
                     rx_left = rx_left - 8'd1;
                     if (rx_left == 8'd0) rx_st = RX_CHECK;
                  end
                  default: begin
                     // check byte is taken without verification
                     r.kind = KIND_COMPLETE;
                     r.packet_length = rx_len;
                     rx_st = RX_HUNT;
                  end
               endcase
            end
            ACT_LINE_IDLE: rx_st = RX_HUNT;
            ACT_LOAD:      tx_buf[idx] = b;
            ACT_TX_START: begin
               tx_st = TX_LEN;
               tx_len = len;
               tx_pos = 8'd0;
               tx_on = 1'b1;
               r.kind = KIND_LINE;
               r.out_byte = MARK_START;
            end
            ACT_TX_READY: begin
               if (tx_on) begin
                  r.kind = KIND_LINE;
                  case (tx_st)
                     TX_LEN: begin
                        r.out_byte = tx_len;
                        if (tx_len != 8'd0) tx_st = TX_DATA;
                        else tx_st = TX_END;
                     end
                     TX_DATA: begin
                        r.out_byte = tx_buf[tx_pos];
                        tx_pos = tx_pos + 8'd1;
                        if (tx_pos == tx_len) tx_st = TX_END;
                     end
                     default: begin
                        r.out_byte = MARK_END;
                        tx_on = 1'b0;
                     end
                  endcase
               end
            end
            default: ;
         endcase
         r.tx_busy = tx_on;
      end
   endtask

   always @(posedge clock) begin
      framer_rsp_type want;
      if (reset) begin
         rx_st = RX_HUNT;
         rx_left = 8'd0;
         rx_len = 8'd0;
         rx_pos = 8'd0;
         tx_st = TX_LEN;
         tx_len = 8'd0;
         tx_pos = 8'd0;
         tx_on = 1'b0;
         owed_q.delete();
         owed <= 0;
      end else begin
         // pop before push so a response never matches its own request edge
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               report($sformatf("response transfer with nothing owed, kind %0d", rsp_kind));
            end else begin
               want = owed_q.pop_front();
               if (rsp_kind !== want.kind)
                  report($sformatf("kind got %0d exp %0d", rsp_kind, want.kind));
               if (rsp_out_byte !== want.out_byte)
                  report($sformatf("out_byte got %0h exp %0h", rsp_out_byte, want.out_byte));
               if (rsp_position !== want.position)
                  report($sformatf("position got %0d exp %0d", rsp_position, want.position));
               if (rsp_packet_length !== want.packet_length)
                  report($sformatf("packet_length got %0d exp %0d",
                                   rsp_packet_length, want.packet_length));
               if (rsp_tx_busy !== want.tx_busy)
                  report($sformatf("tx_busy got %0b exp %0b", rsp_tx_busy, want.tx_busy));
            end
         end
         if (req_valid && req_ready) begin
            step_framer(req_action, req_byte_value, req_load_index, req_tx_length, want);
            owed_q.push_back(want);
         end
         owed <= owed_q.size();
      end
   end

endmodule

// ===== verif/serial_packet_framer_deframer_core_tb.sv =====
// serial_packet_framer_deframer_core_tb: drives directed and random request
// streams with random idling on both channels and gives the verdict
// depends on sfd_pkg, the core and sfd_response_checker

module serial_packet_framer_deframer_core_tb;
   import sfd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_action = '0;
   logic [7:0] req_byte_value = '0;
   logic [7:0] req_load_index = '0;
   logic [7:0] req_tx_length = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_position;
   logic [7:0] rsp_packet_length;
   logic       rsp_tx_busy;

   int fail_count;
   int owed;
   int cycle_count = 0;
   int req_idle_pct = 14;
   int rsp_idle_pct = 60;
   int rsp_hold = 0;
   int sent = 0;

   // loaded buffer entries; prefix counts the leading loaded run
   bit written [0:255];
   int prefix = 0;

   always #4 clock = ~clock;

   serial_packet_framer_deframer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_byte_value    (req_byte_value),
      .req_load_index    (req_load_index),
      .req_tx_length     (req_tx_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_position      (rsp_position),
      .rsp_packet_length (rsp_packet_length),
      .rsp_tx_busy       (rsp_tx_busy)
   );

   sfd_response_checker rsp_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_byte_value    (req_byte_value),
      .req_load_index    (req_load_index),
      .req_tx_length     (req_tx_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_position      (rsp_position),
      .rsp_packet_length (rsp_packet_length),
      .rsp_tx_busy       (rsp_tx_busy),
      .fail_count        (fail_count),
      .owed              (owed)
   );

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("FAIL serial_packet_framer_deframer_core");
      $finish;
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   // one request transfer; a start never asks for unloaded buffer entries
   task automatic put(input logic [2:0] act, input logic [7:0] b,
                      input logic [7:0] idx, input logic [7:0] len);
      logic [7:0] safe_len;
      begin
         safe_len = len;
         if (act == ACT_TX_START && prefix < 256 && len > prefix) safe_len = prefix[7:0];
         while ($urandom_range(0, 99) < req_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_action <= act;
         req_byte_value <= b;
         req_load_index <= idx;
         req_tx_length <= safe_len;
         do @(posedge clock); while (!req_ready);
         if (act == ACT_LOAD) begin
            written[idx] = 1'b1;
            while (prefix < 256 && written[prefix]) prefix = prefix + 1;
         end
         sent = sent + 1;
      end
   endtask

   // load that mostly extends the loaded run
   task automatic load_some();
      logic [7:0] idx;
      begin
         if (prefix < 256 && $urandom_range(0, 9) < 7) idx = prefix[7:0];
         else idx = rnd8();
         put(ACT_LOAD, rnd8(), idx, rnd8());
      end
   endtask

   task automatic drain_responses();
      begin
         req_valid <= 1'b0;
         do @(posedge clock); while (owed != 0);
      end
   endtask

   function automatic int short_len();
      int cap;
      cap = (prefix > 255) ? 255 : prefix;
      if ($urandom_range(0, 99) < 3) return $urandom_range(0, cap);
      return $urandom_range(0, (cap < 12) ? cap : 12);
   endfunction

   initial begin
      int ph;
      int r;
      int k;
      int i;
      int len;
      int cut;
      bit broken;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle ready, unknown actions, hunting bytes, buffer edges
      put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
      put(3'd5, 8'hFF, 8'hFF, 8'hFF);
      put(3'd7, 8'h00, 8'h00, 8'h00);
      put(ACT_RX_BYTE, 8'h00, rnd8(), rnd8());
      put(ACT_RX_BYTE, 8'hFF, rnd8(), rnd8());
      put(ACT_RX_BYTE, MARK_PING, rnd8(), rnd8());
      put(ACT_LOAD, 8'h00, 8'd0, 8'h00);
      put(ACT_LOAD, 8'hFF, 8'd1, 8'hFF);
      put(ACT_LOAD, 8'h5A, 8'd2, 8'h00);
      put(ACT_LOAD, 8'hC3, 8'd255, 8'hFF);
      // zero length frame: marker, length, end byte
      put(ACT_TX_START, rnd8(), rnd8(), 8'd0);
      put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
      put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
      // restart while busy
      put(ACT_TX_START, rnd8(), rnd8(), 8'd2);
      put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
      put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
      put(ACT_TX_START, rnd8(), rnd8(), 8'd1);
      put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
      put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
      put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
      // zero length packet, then a packet cut by line idle
      put(ACT_RX_BYTE, MARK_START, rnd8(), rnd8());
      put(ACT_RX_BYTE, 8'd0, rnd8(), rnd8());
      put(ACT_RX_BYTE, 8'hFF, rnd8(), rnd8());
      put(ACT_RX_BYTE, MARK_START, rnd8(), rnd8());
      put(ACT_RX_BYTE, 8'd2, rnd8(), rnd8());
      put(ACT_RX_BYTE, 8'hFF, rnd8(), rnd8());
      put(ACT_LINE_IDLE, rnd8(), rnd8(), rnd8());
      drain_responses();

      sent = 0;
      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               req_idle_pct = 14;
               rsp_idle_pct = 60;
            end
            1: begin
               req_idle_pct = 60;
               rsp_idle_pct = 14;
               rsp_hold = 300;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               drain_responses();
               rsp_hold = 300;
            end
         endcase
         while (sent < (ph + 1) * PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               // receive packet, sometimes broken off by line idle
               if ($urandom_range(0, 1)) put(ACT_LINE_IDLE, rnd8(), rnd8(), rnd8());
               if ($urandom_range(0, 4) == 0) put(ACT_RX_BYTE, MARK_PING, rnd8(), rnd8());
               put(ACT_RX_BYTE, MARK_START, rnd8(), rnd8());
               len = ($urandom_range(0, 99) < 2) ? $urandom_range(0, 255) : $urandom_range(0, 8);
               put(ACT_RX_BYTE, len[7:0], rnd8(), rnd8());
               broken = ($urandom_range(0, 99) < 10);
               cut = $urandom_range(0, len);
               i = 0;
               while (i < len && !(broken && i == cut)) begin
                  put(ACT_RX_BYTE, rnd8(), rnd8(), rnd8());
                  i = i + 1;
               end
               if (broken) put(ACT_LINE_IDLE, rnd8(), rnd8(), rnd8());
               else put(ACT_RX_BYTE, rnd8(), rnd8(), rnd8());
            end else if (r < 55) begin
               // transmit frame with receive traffic and restarts mixed in
               repeat ($urandom_range(0, 4)) load_some();
               len = short_len();
               put(ACT_TX_START, rnd8(), rnd8(), len[7:0]);
               k = len + 2;
               while (k > 0) begin
                  i = $urandom_range(0, 99);
                  if (i < 10) begin
                     put(ACT_RX_BYTE, rnd8(), rnd8(), rnd8());
                  end else if (i < 15) begin
                     put(ACT_LOAD, rnd8(), rnd8(), rnd8());
                  end else if (i < 17) begin
                     len = short_len();
                     put(ACT_TX_START, rnd8(), rnd8(), len[7:0]);
                     k = len + 2;
                  end else begin
                     put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
                     k = k - 1;
                  end
               end
               if ($urandom_range(0, 9) == 0) put(ACT_TX_READY, rnd8(), rnd8(), rnd8());
            end else if (r < 75) begin
               repeat ($urandom_range(1, 8)) load_some();
            end else if (r < 85) begin
               put(ACT_RX_BYTE, $urandom_range(0, 1) ? MARK_PING : rnd8(), rnd8(), rnd8());
            end else begin
               put(3'($urandom_range(0, 7)), rnd8(), rnd8(), rnd8());
            end
         end
      end

      drain_responses();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && owed == 0) begin
         $display("PASS serial_packet_framer_deframer_core");
      end else begin
         $display("FAIL serial_packet_framer_deframer_core");
      end
      $finish;
   end

endmodule
